/* rtl/core/alh_pkg.sv */
// ----------------------------------------------------------------------------
// alh_pkg
// shared types, codes and defaults for the adaptive latency histogram
// ----------------------------------------------------------------------------
package alh_pkg;

  localparam int BIN_COUNT_DEF = 16;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_RESTART     = 2'd1,
    STAT_NOT_RUNNING = 2'd2,
    STAT_MISS        = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_CLEAR,
    S_WIDTH_GO,
    S_WIDTH_WAIT,
    S_BIN_GO,
    S_BIN_WAIT,
    S_FETCH,
    S_INC,
    S_DONE
  } state_e;

  // divider command and reply
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // one result as held in the output register
  typedef struct packed {
    status_e     status;
    logic [31:0] duration;
    logic [3:0]  bin_hit;
    logic [31:0] bin_count;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [31:0] miss_total;
    logic [31:0] reset_total;
    logic [31:0] sample_total;
  } rsp_t;

endpackage

/* rtl/core/alh_if.sv */
// ----------------------------------------------------------------------------
// alh_req_if / alh_rsp_if
// valid/ready channels for timing requests and histogram results
// ----------------------------------------------------------------------------
interface alh_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] timestamp;
  logic [3:0]  bin_index;

  modport source (output valid, operation, timestamp, bin_index, input ready);
  modport sink   (input valid, operation, timestamp, bin_index, output ready);
endinterface

interface alh_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] duration;
  logic [3:0]  bin_hit;
  logic [31:0] bin_count;
  logic [31:0] range_low;
  logic [31:0] range_high;
  logic [31:0] miss_total;
  logic [31:0] reset_total;
  logic [31:0] sample_total;

  modport source (output valid, status, duration, bin_hit, bin_count, range_low,
                  range_high, miss_total, reset_total, sample_total, input ready);
  modport sink   (input valid, status, duration, bin_hit, bin_count, range_low,
                  range_high, miss_total, reset_total, sample_total, output ready);
endinterface

/* rtl/core/alh_div.sv */
// ----------------------------------------------------------------------------
// alh_div
// 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module alh_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alh_pkg::div_req_t req_i,
  output alh_pkg::div_rsp_t rsp_o
);
  import alh_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quot_q[31]} - {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      // trial subtract, keep it when it does not go negative
      if (!trial[32]) begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = {rem_q[30:0], quot_q[31]};
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

/* rtl/core/alh_hist.sv */
// ----------------------------------------------------------------------------
// alh_hist
// histogram bin store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module alh_hist #(
  parameter int BinCount = alh_pkg::BIN_COUNT_DEF,
  localparam int AddrW   = $clog2(BinCount)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [31:0]      wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [31:0]      rd_data_o
);
  import alh_pkg::*;

  logic [31:0] mem [BinCount];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/adaptive_latency_histogram.sv */
// ----------------------------------------------------------------------------
// adaptive_latency_histogram
// self-ranging latency histogram timed by 64-bit request timestamps
// ----------------------------------------------------------------------------
// sequence: start, failed stop and out-of-range read go straight to the result,
//   a bin read reads the store first; an in-range stop divides for the bin index,
//   then bumps the bin; a widening stop first clears all bins and divides for the width
// throughput: one request at a time; a result waits in its own register, so
//   the next request is taken while it is still pending
// reset: totals, bounds, timer clear; bins swept to zero one at a time, no request taken
// ----------------------------------------------------------------------------
module adaptive_latency_histogram #(
  parameter int BinCount = alh_pkg::BIN_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  alh_req_if.sink   req_i,
  alh_rsp_if.source rsp_o
);
  import alh_pkg::*;

  localparam int               AddrW     = $clog2(BinCount);
  localparam logic [AddrW-1:0] LastBin   = AddrW'(BinCount - 1);
  localparam logic [8:0]       BinCountW = 9'(BinCount);

  // sequencer and timer state
  state_e      state_q, state_d;
  logic        running_q, running_d;
  logic [63:0] start_q, start_d;
  // range tracking and totals
  logic [31:0] low_q, low_d;
  logic [31:0] high_q, high_d;
  logic [31:0] width_q, width_d;
  logic [31:0] miss_q, miss_d;
  logic [31:0] resets_q, resets_d;
  logic [31:0] samples_q, samples_d;
  logic [AddrW-1:0] clr_ptr_q, clr_ptr_d;
  // per-request working values
  logic [31:0]      dur_q, dur_d;
  logic [AddrW-1:0] bin_q, bin_d;
  status_e          status_q, status_d;
  logic [3:0]       hit_q, hit_d;
  logic [31:0]      count_q, count_d;
  // output register
  logic rsp_valid_q, rsp_valid_d;
  rsp_t out_q, out_d;

  // shared divider and bin store
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic [AddrW-1:0] rd_addr;
  logic [31:0]      rd_data;

  // timestamp split and gap classification
  logic [31:0]      sh, sl, th, tl;
  logic             same_word, one_wrap;
  logic [31:0]      offset;
  logic [31:0]      bin_src;
  logic [AddrW-1:0] bin_sat;

  alh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  alh_hist #(
    .BinCount (BinCount)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    sh = start_q[63:32];
    sl = start_q[31:0];
    th = req_i.timestamp[63:32];
    tl = req_i.timestamp[31:0];
    same_word = (sh == th);
    // stop one high word later with a smaller low word: a single wrap
    one_wrap  = (sh == (th - 32'd1)) && (sl > tl);
    offset    = dur_q - low_q;
    // zero width never divides: offset stands in for the quotient
    bin_src   = (width_q == '0) ? offset : div_rsp.quotient;
    // indexes past the end land in the last bin
    bin_sat   = (bin_src >= 32'(BinCount)) ? LastBin : AddrW'(bin_src);
  end

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    start_d     = start_q;
    low_d       = low_q;
    high_d      = high_q;
    width_d     = width_q;
    miss_d      = miss_q;
    resets_d    = resets_q;
    samples_d   = samples_q;
    clr_ptr_d   = clr_ptr_q;
    dur_d       = dur_q;
    bin_d       = bin_q;
    status_d    = status_q;
    hit_d       = hit_q;
    count_d     = count_q;
    out_d       = out_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    div_req     = '0;
    wr_en       = 1'b0;
    wr_addr     = clr_ptr_q;
    wr_data     = '0;
    rd_addr     = bin_q;
    req_i.ready = 1'b0;

    unique case (state_q)
      // sweep the bin store to zero after reset
      S_INIT: begin
        wr_en = 1'b1;
        if (clr_ptr_q == LastBin) begin
          clr_ptr_d = '0;
          state_d   = S_IDLE;
        end else begin
          clr_ptr_d = clr_ptr_q + 1'b1;
        end
      end

      S_IDLE: begin
        req_i.ready = 1'b1;
        rd_addr     = AddrW'(req_i.bin_index);
        if (req_i.valid) begin
          status_d = STAT_OK;
          dur_d    = '0;
          hit_d    = '0;
          count_d  = '0;
          state_d  = S_DONE;
          unique case (req_i.operation)
            OP_START: begin
              if (running_q) begin
                status_d = STAT_RESTART;
              end else begin
                start_d   = req_i.timestamp;
                running_d = 1'b1;
              end
            end
            OP_STOP: begin
              if (!running_q) begin
                status_d = STAT_NOT_RUNNING;
              end else if (same_word || one_wrap) begin
                running_d = 1'b0;
                dur_d     = tl - sl;
                state_d   = S_CHECK;
              end else begin
                miss_d   = miss_q + 32'd1;
                status_d = STAT_MISS;
              end
            end
            OP_READ: begin
              // bin store read issued this cycle, data next cycle
              if (9'(req_i.bin_index) < BinCountW) begin
                state_d = S_READ;
              end
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        count_d = rd_data;
        state_d = S_DONE;
      end

      // widen the range when the duration falls outside it
      S_CHECK: begin
        if (low_q == '0 || dur_q < low_q || dur_q > high_q) begin
          if (low_q == '0 || dur_q < low_q) begin
            low_d = dur_q;
          end
          if (high_q == '0 || dur_q > high_q) begin
            high_d = dur_q;
          end
          resets_d  = resets_q + 32'd1;
          clr_ptr_d = '0;
          state_d   = S_CLEAR;
        end else begin
          state_d = S_BIN_GO;
        end
      end

      S_CLEAR: begin
        wr_en = 1'b1;
        if (clr_ptr_q == LastBin) begin
          clr_ptr_d = '0;
          state_d   = S_WIDTH_GO;
        end else begin
          clr_ptr_d = clr_ptr_q + 1'b1;
        end
      end

      // bin width = range / (bins + 1), at least 1
      S_WIDTH_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = high_q - low_q;
        div_req.divisor  = 32'(BinCount + 1);
        state_d          = S_WIDTH_WAIT;
      end

      S_WIDTH_WAIT: begin
        if (div_rsp.done) begin
          width_d = (div_rsp.quotient == '0) ? 32'd1 : div_rsp.quotient;
          state_d = S_BIN_GO;
        end
      end

      // bin index = (d - low) / width, saturated to the last bin
      S_BIN_GO: begin
        if (width_q == '0) begin
          bin_d   = bin_sat;
          state_d = S_FETCH;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = offset;
          div_req.divisor  = width_q;
          state_d          = S_BIN_WAIT;
        end
      end

      S_BIN_WAIT: begin
        if (div_rsp.done) begin
          bin_d   = bin_sat;
          state_d = S_FETCH;
        end
      end

      S_FETCH: begin
        rd_addr = bin_q;
        state_d = S_INC;
      end

      // read-modify-write of the hit bin
      S_INC: begin
        wr_en     = 1'b1;
        wr_addr   = bin_q;
        wr_data   = rd_data + 32'd1;
        samples_d = samples_q + 32'd1;
        hit_d     = 4'(bin_q);
        state_d   = S_DONE;
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          out_d.status       = status_q;
          out_d.duration     = dur_q;
          out_d.bin_hit      = hit_q;
          out_d.bin_count    = count_q;
          out_d.range_low    = low_q;
          out_d.range_high   = high_q;
          out_d.miss_total   = miss_q;
          out_d.reset_total  = resets_q;
          out_d.sample_total = samples_q;
          rsp_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      running_q   <= 1'b0;
      low_q       <= '0;
      high_q      <= '0;
      width_q     <= '0;
      miss_q      <= '0;
      resets_q    <= '0;
      samples_q   <= '0;
      clr_ptr_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      low_q       <= low_d;
      high_q      <= high_d;
      width_q     <= width_d;
      miss_q      <= miss_d;
      resets_q    <= resets_d;
      samples_q   <= samples_d;
      clr_ptr_q   <= clr_ptr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    dur_q    <= dur_d;
    bin_q    <= bin_d;
    status_q <= status_d;
    hit_q    <= hit_d;
    count_q  <= count_d;
    out_q    <= out_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.duration     = out_q.duration;
  assign rsp_o.bin_hit      = out_q.bin_hit;
  assign rsp_o.bin_count    = out_q.bin_count;
  assign rsp_o.range_low    = out_q.range_low;
  assign rsp_o.range_high   = out_q.range_high;
  assign rsp_o.miss_total   = out_q.miss_total;
  assign rsp_o.reset_total  = out_q.reset_total;
  assign rsp_o.sample_total = out_q.sample_total;

endmodule

/* tb/adaptive_latency_histogram_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_latency_histogram_checker
// watches both channels, keeps its own copy of the timer, range and bins,
// and compares every result field with the one it worked out
// ----------------------------------------------------------------------------
module adaptive_latency_histogram_checker (
  input  logic clk_i,
  input  logic rst_ni,
  alh_req_if   req_i,
  alh_rsp_if   rsp_i,
  output int   mismatch_o,
  output int   due_o,
  output int   seen_o
);
  import alh_pkg::*;

  localparam int Bins = BIN_COUNT_DEF;

  logic        timer_on;
  logic [63:0] t_begin;
  logic [31:0] span_lo;
  logic [31:0] span_hi;
  logic [31:0] bin_step;
  logic [31:0] bin_tally [Bins];
  logic [31:0] n_miss;
  logic [31:0] n_widen;
  logic [31:0] n_sample;
  rsp_t        awaited_results [$];
  rsp_t        want;

  function automatic void clear_timer_state();
    timer_on = 1'b0;
    t_begin  = '0;
    span_lo  = '0;
    span_hi  = '0;
    bin_step = '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    n_miss   = '0;
    n_widen  = '0;
    n_sample = '0;
  endfunction

  // result of one timing request, updating the timer and histogram copy
  function automatic rsp_t time_event(input logic [1:0] op, input logic [63:0] ts,
                                      input logic [3:0] idx);
    rsp_t        r;
    logic [31:0] dur;
    logic [31:0] slot;
    logic        fits;
    r = '0;
    case (op)
      OP_START: begin
        if (timer_on) begin
          r.status = STAT_RESTART;
        end else begin
          t_begin  = ts;
          timer_on = 1'b1;
        end
      end
      OP_STOP: begin
        if (!timer_on) begin
          r.status = STAT_NOT_RUNNING;
        end else begin
          // same high word, or one step up with the low word wrapped
          fits = (ts[63:32] == t_begin[63:32]) ||
                 (t_begin[63:32] == ts[63:32] - 32'd1 && t_begin[31:0] > ts[31:0]);
          if (!fits) begin
            n_miss++;
            r.status = STAT_MISS;
          end else begin
            dur      = ts[31:0] - t_begin[31:0];
            timer_on = 1'b0;
            if (span_lo == 0 || dur < span_lo || dur > span_hi) begin
              if (span_lo == 0 || dur < span_lo) span_lo = dur;
              if (span_hi == 0 || dur > span_hi) span_hi = dur;
              foreach (bin_tally[i]) bin_tally[i] = '0;
              bin_step = (span_hi - span_lo) / 32'(Bins + 1);
              if (bin_step == 0) bin_step = 32'd1;
              n_widen++;
            end
            slot = (dur - span_lo) / bin_step;
            if (slot >= Bins) slot = Bins - 1;
            bin_tally[slot]++;
            n_sample++;
            r.duration = dur;
            r.bin_hit  = slot[3:0];
          end
        end
      end
      OP_READ: begin
        if (idx < Bins) r.bin_count = bin_tally[idx];
      end
      default: ;
    endcase
    r.range_low    = span_lo;
    r.range_high   = span_hi;
    r.miss_total   = n_miss;
    r.reset_total  = n_widen;
    r.sample_total = n_sample;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatch_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_timer_state();
      awaited_results.delete();
      mismatch_o = 0;
      seen_o     = 0;
      due_o     <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing outstanding: status %0d", rsp_i.status);
          mismatch_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, rsp_i.status);
          check_field("duration", want.duration, rsp_i.duration);
          check_field("bin_hit", want.bin_hit, rsp_i.bin_hit);
          check_field("bin_count", want.bin_count, rsp_i.bin_count);
          check_field("range_low", want.range_low, rsp_i.range_low);
          check_field("range_high", want.range_high, rsp_i.range_high);
          check_field("miss_total", want.miss_total, rsp_i.miss_total);
          check_field("reset_total", want.reset_total, rsp_i.reset_total);
          check_field("sample_total", want.sample_total, rsp_i.sample_total);
          seen_o++;
        end
      end
      if (req_i.valid && req_i.ready) begin
        awaited_results.push_back(time_event(req_i.operation, req_i.timestamp,
                                             req_i.bin_index));
      end
      due_o <= awaited_results.size();
    end
  end

endmodule

/* tb/adaptive_latency_histogram_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_latency_histogram_tb
// start, stop, bin-read and unused requests against the latency histogram: a
// directed opening, then random timing sequences under three idle patterns,
// with results checked field by field by the companion checker
// ----------------------------------------------------------------------------
module adaptive_latency_histogram_tb;
  import alh_pkg::*;

  // encoding the block ignores; it still answers with one result
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ItemsPerPhase = 450;
  // longest request is a range-widening stop
  localparam int SettleCycles = 150;

  logic clk_i;
  logic rst_ni;

  alh_req_if req_if ();
  alh_rsp_if rsp_if ();

  int mismatches;
  int results_due;
  int results_seen;

  // idle odds in percent for each side, changed per phase
  int src_idle_pct;
  int rcv_idle_pct;

  // rough view of the timer, only used to shape the stimulus
  logic        armed;
  logic [63:0] t0;

  int sent_starts;
  int sent_stops;
  int sent_reads;
  int sent_unused;

  adaptive_latency_histogram dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  adaptive_latency_histogram_checker u_hist_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .mismatch_o(mismatches),
    .due_o     (results_due),
    .seen_o    (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver side: ready drops at random with the current odds
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // keep the stimulus view of the timer in step with what was sent
  function automatic void note_sent(input logic [1:0] op, input logic [63:0] ts);
    case (op)
      OP_START: begin
        sent_starts++;
        if (!armed) begin
          armed = 1'b1;
          t0    = ts;
        end
      end
      OP_STOP: begin
        sent_stops++;
        if (armed && (ts[63:32] == t0[63:32] ||
                      (t0[63:32] == ts[63:32] - 32'd1 && t0[31:0] > ts[31:0])))
          armed = 1'b0;
      end
      OP_READ: sent_reads++;
      default: sent_unused++;
    endcase
  endfunction

  // present one request, with a random gap first, and hold it until taken
  task automatic send(input logic [1:0] op, input logic [63:0] ts, input logic [3:0] idx);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.timestamp <= ts;
    req_if.bin_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    note_sent(op, ts);
  endtask

  // stop sending until every outstanding result has been taken
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  // mostly full-width durations, since the range only ever widens and the
  // opening part already stretches it across the whole 32-bit span
  function automatic logic [31:0] pick_duration();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return $urandom_range(3);
    if (sel < 25) return $urandom_range(3000);
    if (sel < 30) return 32'hFFFF_FFFF - $urandom_range(255);
    return $urandom;
  endfunction

  task automatic random_request();
    int          sel;
    logic [63:0] any_ts;
    logic [3:0]  any_idx;
    sel     = $urandom_range(99);
    any_ts  = {$urandom, $urandom};
    any_idx = 4'($urandom_range(15));
    if (!armed) begin
      if (sel < 78) send(OP_START, any_ts, any_idx);
      else if (sel < 86) send(OP_STOP, any_ts, any_idx);       // stop while idle
      else if (sel < 97) send(OP_READ, any_ts, any_idx);
      else send(OP_UNUSED, any_ts, any_idx);
    end else begin
      // well-formed stop: start time plus a duration, possibly across a wrap
      if (sel < 68) send(OP_STOP, t0 + 64'(pick_duration()), any_idx);
      // gap of more than one low-word wrap
      else if (sel < 76) send(OP_STOP, t0 + {32'($urandom_range(1, 8)), $urandom}, any_idx);
      else if (sel < 79) send(OP_STOP, any_ts, any_idx);
      else if (sel < 86) send(OP_START, any_ts, any_idx);    // restart attempt
      else if (sel < 98) send(OP_READ, any_ts, any_idx);
      else send(OP_UNUSED, any_ts, any_idx);
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_START;
    req_if.timestamp <= '0;
    req_if.bin_index <= '0;
    src_idle_pct      = 17;
    rcv_idle_pct      = 85;
    armed             = 1'b0;
    t0                = '0;
    sent_starts       = 0;
    sent_stops        = 0;
    sent_reads        = 0;
    sent_unused       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening
    send(OP_STOP, 64'h0, 4'h0);                          // stop while idle
    send(OP_READ, 64'h0, 4'h0);                          // empty bin
    send(OP_UNUSED, '1, 4'hF);                           // ignored encoding
    send(OP_START, 64'h0, 4'h0);
    send(OP_START, '1, 4'h0);                            // start while running
    send(OP_STOP, 64'h0, 4'h0);                          // zero duration
    send(OP_START, 64'hFFFF_FFFF_FFFF_FFF0, 4'h0);
    send(OP_STOP, 64'h0000_0000_0000_0010, 4'h0);        // wrap of both words, width floor
    send(OP_START, 64'h0000_0005_8000_0000, 4'h0);
    send(OP_STOP, 64'h0000_0007_0000_0000, 4'h0);        // miss, timer keeps running
    send(OP_STOP, 64'h0000_0006_7FFF_FFFF, 4'h0);        // longest duration, last bin
    send(OP_START, 64'h0000_0001_0000_0000, 4'h0);
    send(OP_STOP, 64'h0000_0001_0000_03E8, 4'h0);        // inside the range
    send(OP_START, 64'hFFFF_FFFF_0000_0010, 4'h0);
    send(OP_STOP, 64'h0000_0000_0000_0020, 4'h0);        // high step without low wrap
    send(OP_STOP, 64'h0000_0000_0000_0008, 4'h0);        // bin index past the end
    send(OP_START, 64'h0000_0000_1234_5678, 4'h0);
    send(OP_STOP, 64'h0000_0000_1234_5678, 4'h0);        // zero below the low bound
    send(OP_START, 64'h0, 4'h0);
    send(OP_STOP, 64'h5, 4'h0);                          // low bound unset, widens again
    send(OP_READ, 64'h0, 4'hF);
    send(OP_READ, 64'h0, 4'h0);
    send(OP_READ, 64'h0, 4'h5);
    wait_drained();

    // random timing sequences, one idle pattern per phase
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 85 : 0;
      rcv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 17 : 0;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        random_request();
        if (ph == 1 && k == ItemsPerPhase / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d starts, %0d stops, %0d bin reads, %0d unused requests",
             sent_starts, sent_stops, sent_reads, sent_unused);
    $display("%0d results compared under three idle patterns", results_seen);
    if (mismatches == 0) begin
      $display("adaptive_latency_histogram regression: pass");
    end else begin
      $display("adaptive_latency_histogram regression: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #4000000;
    $display("adaptive_latency_histogram regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/core/alh_pkg.sv
rtl/core/alh_if.sv
rtl/core/alh_div.sv
rtl/core/alh_hist.sv
rtl/core/adaptive_latency_histogram.sv
tb/adaptive_latency_histogram_checker.sv
tb/adaptive_latency_histogram_tb.sv
